// File: rtl/core/set_assoc_cache_tag_policy_core_assert.svh
// Assertion macros for the cache tag and replacement engine.
// Included by the files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef SET_ASSOC_CACHE_TAG_POLICY_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_POLICY_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SACP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SACP_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SACP_ASSERT(label, prop, msg)
`define SACP_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// File: rtl/core/sacp_pkg.sv
// Shared types and constants of the cache tag and replacement engine.
// No dependencies; sacp_if, sacp_victim, sacp_lookup and the top level use it.
package sacp_pkg;

  localparam int NUM_SETS   = 64;
  localparam int NUM_WAYS   = 4;
  localparam int LINE_BYTES = 64;
  localparam int ADDR_BITS  = 32;

  localparam int OFF_BITS  = $clog2(LINE_BYTES);
  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - SET_BITS;
  localparam int WAY_BITS  = 2;
  localparam int VLA_BITS  = 26;
  localparam int CNT_BITS  = 8;
  localparam int POL_BITS  = 2;

  localparam logic [CNT_BITS-1:0] AGE_MAX = 8'd255;
  localparam logic [CNT_BITS-1:0] USE_MAX = 8'd255;

  localparam logic [POL_BITS-1:0] POL_LRU  = 2'd0;
  localparam logic [POL_BITS-1:0] POL_MRU  = 2'd1;
  localparam logic [POL_BITS-1:0] POL_LFU  = 2'd2;
  localparam logic [POL_BITS-1:0] POL_WAY0 = 2'd3;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [TAG_BITS-1:0] tag;
    logic [CNT_BITS-1:0] age;
    logic [CNT_BITS-1:0] use_cnt;
  } way_ent_t;

  typedef way_ent_t [NUM_WAYS-1:0] set_row_t;

  localparam int ROW_BITS = $bits(set_row_t);

  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] way_used;
    logic                fill_needed;
    logic                writeback;
    logic [VLA_BITS-1:0] victim_line_address;
  } lookup_res_t;

endpackage

// File: rtl/core/sacp_if.sv
// Valid/ready channel interfaces for the access and result items.
// Depends on sacp_pkg for field widths.
interface sacp_req_if;
  logic                            valid;
  logic                            ready;
  logic                            command;
  logic [sacp_pkg::ADDR_BITS-1:0]  byte_address;

  modport source (output valid, output command, output byte_address, input ready);
  modport sink   (input valid, input command, input byte_address, output ready);
endinterface

interface sacp_res_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [sacp_pkg::WAY_BITS-1:0]   way_used;
  logic                            fill_needed;
  logic                            writeback;
  logic [sacp_pkg::VLA_BITS-1:0]   victim_line_address;

  modport source (output valid, output hit, output way_used, output fill_needed,
                  output writeback, output victim_line_address, input ready);
  modport sink   (input valid, input hit, input way_used, input fill_needed,
                  input writeback, input victim_line_address, output ready);
endinterface

// File: rtl/core/sacp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sacp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/sacp_victim.sv
// Replacement victim selection over the (already aged) ways of one set.
// Depends on sacp_pkg.
module sacp_victim (
  input  sacp_pkg::set_row_t                row,
  input  logic [sacp_pkg::POL_BITS-1:0]     policy,
  output logic [sacp_pkg::WAY_BITS-1:0]     victim_way
);
  import sacp_pkg::*;

  always_comb begin
    logic [CNT_BITS-1:0] key;
    logic [CNT_BITS-1:0] v;
    logic                better;
    logic [WAY_BITS-1:0] best;
    best = '0;
    key  = (policy == POL_LFU) ? row[0].use_cnt : row[0].age;
    // Strict comparisons keep the lowest way on a tie.
    for (int w = 1; w < NUM_WAYS; w++) begin
      v      = (policy == POL_LFU) ? row[w].use_cnt : row[w].age;
      better = (policy == POL_LRU) ? (v > key) : (v < key);
      if (better) begin
        key  = v;
        best = WAY_BITS'(w);
      end
    end
    if (policy == POL_WAY0) begin
      best = '0;
    end
    victim_way = best;
  end

endmodule

// File: rtl/core/sacp_lookup.sv
// Tag compare, allocation and state update for one access against one set row.
// Depends on sacp_pkg and sacp_victim.
module sacp_lookup (
  input  sacp_pkg::set_row_t                row_in,
  input  logic [sacp_pkg::TAG_BITS-1:0]     tag,
  input  logic [sacp_pkg::SET_BITS-1:0]     set_idx,
  input  logic                              command,
  input  logic [sacp_pkg::POL_BITS-1:0]     policy,
  output sacp_pkg::set_row_t                row_out,
  output sacp_pkg::lookup_res_t             res
);
  import sacp_pkg::*;

  set_row_t            aged;
  logic [WAY_BITS-1:0] victim_way;

  // Every way of the set below AGE_MAX ages by one before the victim is chosen.
  always_comb begin
    aged = row_in;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (row_in[w].age != AGE_MAX) begin
        aged[w].age = row_in[w].age + CNT_BITS'(1);
      end
    end
  end

  sacp_victim u_victim (
    .row        (aged),
    .policy     (policy),
    .victim_way (victim_way)
  );

  always_comb begin
    logic                hit;
    logic                free;
    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] free_way;
    logic [WAY_BITS-1:0] way;
    logic                wb;
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    // Scanning downwards leaves the lowest matching way selected.
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row_in[w].valid && (row_in[w].tag == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!row_in[w].valid) begin
        free     = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end

    if (hit) begin
      way = hit_way;
    end else if (free) begin
      way = free_way;
    end else begin
      way = victim_way;
    end
    wb = !hit && !free && aged[way].dirty;

    row_out = aged;
    row_out[way].age = '0;
    if (hit) begin
      row_out[way].dirty = aged[way].dirty | (command == CMD_WRITE);
      if (aged[way].use_cnt != USE_MAX) begin
        row_out[way].use_cnt = aged[way].use_cnt + CNT_BITS'(1);
      end
    end else begin
      row_out[way].valid   = 1'b1;
      row_out[way].dirty   = (command == CMD_WRITE);
      row_out[way].tag     = tag;
      row_out[way].use_cnt = CNT_BITS'(1);
    end

    res.hit                 = hit;
    res.way_used            = way;
    res.fill_needed         = !hit;
    res.writeback           = wb;
    res.victim_line_address = wb ? VLA_BITS'({aged[way].tag, set_idx}) : '0;
  end

endmodule

// File: rtl/core/set_assoc_cache_tag_policy_core.sv
// Top level of the four-way write-back cache tag and replacement engine.
// Depends on sacp_pkg, sacp_if, sacp_ram, sacp_lookup and the assertion header.
//
// Usage: each item on in_port is one byte read or write (command, byte_address).
// For every item exactly one result item leaves on out_port: hit, the way hit or
// filled, whether a fill is needed, and whether a dirty victim must be written
// back together with its line address. cfg_wr_en/cfg_wr_data load the
// replacement policy (least recent, most recent, least used, way zero).
// Each accepted item is registered into the lookup stage; when the stage advances,
// its result loads the result register, which drives out_port directly.
// Throughput: one item per cycle while results are taken, set by the single read
// and write port of the set memory; an item that hits the set written by the item
// before it takes the updated row from a bypass register instead of the memory.
// Reset clears the policy, the pipeline and one initialised bit per set, so all
// lines read as invalid with zero age and use count; no clearing pass is needed.
// When the receiver stalls, the result register holds, any item behind it waits
// in its stage, and if it does, in_port.ready drops until the result is taken.
`include "set_assoc_cache_tag_policy_core_assert.svh"

module set_assoc_cache_tag_policy_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [sacp_pkg::POL_BITS-1:0] cfg_wr_data,
  sacp_req_if.sink                      in_port,
  sacp_res_if.source                    out_port
);
  import sacp_pkg::*;

  logic [POL_BITS-1:0] policy_r;
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_cmd_r;
  logic [SET_BITS-1:0] s1_set_r;
  logic [TAG_BITS-1:0] s1_tag_r;
  logic [NUM_SETS-1:0] row_init_r;
  logic                row_seen_r;
  logic                byp_sel_r;
  set_row_t            byp_row_r;
  logic                out_valid_r, out_valid_nxt;
  lookup_res_t         out_res_r;

  logic                accept;
  logic                s1_adv;
  logic [SET_BITS-1:0] in_set;
  logic [TAG_BITS-1:0] in_tag;
  logic [ROW_BITS-1:0] ram_rdata;
  set_row_t            row_cur;
  set_row_t            row_new;
  lookup_res_t         res;

  assign in_set = in_port.byte_address[OFF_BITS +: SET_BITS];
  assign in_tag = in_port.byte_address[ADDR_BITS-1 -: TAG_BITS];

  assign s1_adv         = s1_valid_r && (!out_valid_r || out_port.ready);
  assign in_port.ready  = !s1_valid_r || s1_adv;
  assign accept         = in_port.valid && in_port.ready;

  sacp_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_set_r),
    .wdata (row_new),
    .re    (accept),
    .raddr (in_set),
    .rdata (ram_rdata)
  );

  // A set never written since reset reads as all ways invalid and zeroed.
  always_comb begin
    if (byp_sel_r) begin
      row_cur = byp_row_r;
    end else if (row_seen_r) begin
      row_cur = set_row_t'(ram_rdata);
    end else begin
      row_cur = '0;
    end
  end

  sacp_lookup u_lookup (
    .row_in  (row_cur),
    .tag     (s1_tag_r),
    .set_idx (s1_set_r),
    .command (s1_cmd_r),
    .policy  (policy_r),
    .row_out (row_new),
    .res     (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_port.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_LRU;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      row_init_r  <= '0;
      byp_sel_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        policy_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        row_init_r[s1_set_r] <= 1'b1;
      end
      // The memory returns the old row when it is read and written together.
      if (accept) begin
        byp_sel_r <= s1_adv && (s1_set_r == in_set);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r   <= in_port.command;
      s1_set_r   <= in_set;
      s1_tag_r   <= in_tag;
      row_seen_r <= row_init_r[in_set];
      byp_row_r  <= row_new;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_port.valid               = out_valid_r;
  assign out_port.hit                 = out_res_r.hit;
  assign out_port.way_used            = out_res_r.way_used;
  assign out_port.fill_needed         = out_res_r.fill_needed;
  assign out_port.writeback           = out_res_r.writeback;
  assign out_port.victim_line_address = out_res_r.victim_line_address;

  `SACP_ASSERT(a_result_from_stage, $rose(out_valid_r) |-> $past(s1_valid_r), "result without item")
  `SACP_ASSERT_NEVER(a_hit_no_wb, out_valid_r && out_res_r.hit && out_res_r.writeback, "hit with writeback")
  `SACP_ASSERT(a_stage_holds, s1_valid_r && out_valid_r && !out_port.ready |=> s1_valid_r && $stable(s1_set_r), "stage lost")

endmodule
